/* sv/tgtc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgtc_pkg
// Types and constants for the time-gap trigger clusterer.
// ----------------------------------------------------------------------------
package tgtc_pkg;

    localparam int INDEX_WIDTH = 32;
    localparam int TIME_W      = 63;
    localparam int FREQ_W      = 40;
    localparam int SNR_W       = 32;
    localparam int WORD_W      = 64;
    localparam int CNT_W       = 32;
    localparam int GAP_W       = 40;
    localparam int CFG_W       = 40;
    localparam int CFG_IDX_W   = 1;

    localparam logic [GAP_W-1:0] GAP_LIMIT_RESET     = GAP_W'(64'd4294967296);
    localparam logic [SNR_W-1:0] SNR_THRESHOLD_RESET = SNR_W'(32'd655360);

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_GAP_LIMIT     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SNR_THRESHOLD = 1'b1;

    // Input item commands.
    localparam logic CMD_TRIGGER = 1'b0;
    localparam logic CMD_FLUSH   = 1'b1;

    typedef struct packed {
        logic              cmd;
        logic [TIME_W-1:0] peak_time;
        logic [TIME_W-1:0] start_time;
        logic [TIME_W-1:0] end_time;
        logic [FREQ_W-1:0] peak_freq;
        logic [FREQ_W-1:0] low_freq;
        logic [FREQ_W-1:0] high_freq;
        logic [SNR_W-1:0]  snr_in;
        logic [WORD_W-1:0] amp_in;
        logic [WORD_W-1:0] quality_in;
    } t_trig;

    typedef struct packed {
        logic [TIME_W-1:0] cl_time;
        logic [TIME_W-1:0] cl_start;
        logic [TIME_W-1:0] cl_end;
        logic [FREQ_W-1:0] cl_freq;
        logic [FREQ_W-1:0] cl_low_freq;
        logic [FREQ_W-1:0] cl_high_freq;
        logic [SNR_W-1:0]  cl_snr;
        logic [WORD_W-1:0] cl_amp;
        logic [WORD_W-1:0] cl_quality;
        logic [CNT_W-1:0]  cl_first_index;
        logic [CNT_W-1:0]  cl_size;
    } t_cluster;

endpackage

/* sv/time_gap_trigger_clusterer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// time_gap_trigger_clusterer
// Groups time-sorted triggers into clusters separated by a time gap and
// emits each closed cluster whose peak SNR reaches the threshold.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake          Payload
//  trigger   in         i_valid / o_stall  i_data  (t_trig)
//  cluster   out        o_valid / i_stall  o_data  (t_cluster)
//  config    in         i_cfg_we           i_cfg_index, i_cfg_data
//
//  One item is taken per cycle while o_stall is low; the join test and the
//  bound updates are a single 64-bit subtract-compare plus min/max selects
//  in front of the cluster registers. Reset (synchronous, active low) empties
//  the block and loads the register defaults. An output register plus one
//  skid entry absorb a stalled output; o_stall rises only while the skid
//  entry is occupied.
// ----------------------------------------------------------------------------
module time_gap_trigger_clusterer
    import tgtc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  t_trig                i_data,
    output logic                 o_valid,
    input  logic                 i_stall,
    output t_cluster             o_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam logic [INDEX_WIDTH-1:0] INDEX_MAX = '1;
    localparam logic [CNT_W-1:0]       CNT_MAX   = '1;

    logic [GAP_W-1:0]       r_gap_limit;
    logic [SNR_W-1:0]       r_snr_threshold;
    logic                   r_open;
    logic [INDEX_WIDTH-1:0] r_item_counter;
    t_cluster               r_acc;
    t_cluster               n_acc;
    t_cluster               r_out;
    logic                   r_out_valid;
    t_cluster               r_skid;
    logic                   r_skid_valid;

    logic                   w_accept;
    logic                   w_flush;
    logic [WORD_W-1:0]      w_diff;
    logic                   w_join;
    logic                   w_loud;
    logic                   w_emit;
    logic                   w_out_free;
    logic [WORD_W-1:0]      w_cnt_wide;
    logic [CNT_W-1:0]       w_first_index;

    assign o_stall    = r_skid_valid;
    assign w_accept   = i_valid && !o_stall;
    assign w_flush    = (i_data.cmd == CMD_FLUSH);
    assign o_valid    = r_out_valid;
    assign o_data     = r_out;
    assign w_out_free = !r_out_valid || !i_stall;

    // A start before the cluster end borrows and always joins.
    assign w_diff = {1'b0, i_data.start_time} - {1'b0, r_acc.cl_end};
    assign w_join = r_open &&
                    (w_diff[WORD_W-1] ||
                     (w_diff[TIME_W-1:0] < TIME_W'(r_gap_limit)));
    assign w_loud = r_open && (r_acc.cl_snr >= r_snr_threshold);
    assign w_emit = w_accept && w_loud && (w_flush || !w_join);

    assign w_cnt_wide    = WORD_W'(r_item_counter);
    assign w_first_index = (w_cnt_wide > WORD_W'(CNT_MAX)) ? CNT_MAX
                                                           : w_cnt_wide[CNT_W-1:0];

    always_comb begin
        n_acc = r_acc;
        if (w_join) begin
            if (r_acc.cl_size != CNT_MAX) begin
                n_acc.cl_size = r_acc.cl_size + CNT_W'(1);
            end
            if (i_data.end_time > r_acc.cl_end) begin
                n_acc.cl_end = i_data.end_time;
            end
            if (i_data.start_time < r_acc.cl_start) begin
                n_acc.cl_start = i_data.start_time;
            end
            if (i_data.high_freq > r_acc.cl_high_freq) begin
                n_acc.cl_high_freq = i_data.high_freq;
            end
            if (i_data.low_freq < r_acc.cl_low_freq) begin
                n_acc.cl_low_freq = i_data.low_freq;
            end
            // Only a strictly louder tile takes over the peak fields.
            if (i_data.snr_in > r_acc.cl_snr) begin
                n_acc.cl_snr     = i_data.snr_in;
                n_acc.cl_amp     = i_data.amp_in;
                n_acc.cl_time    = i_data.peak_time;
                n_acc.cl_freq    = i_data.peak_freq;
                n_acc.cl_quality = i_data.quality_in;
            end
        end else begin
            n_acc.cl_end         = i_data.end_time;
            n_acc.cl_start       = i_data.start_time;
            n_acc.cl_high_freq   = i_data.high_freq;
            n_acc.cl_low_freq    = i_data.low_freq;
            n_acc.cl_size        = CNT_W'(1);
            n_acc.cl_snr         = i_data.snr_in;
            n_acc.cl_amp         = i_data.amp_in;
            n_acc.cl_time        = i_data.peak_time;
            n_acc.cl_freq        = i_data.peak_freq;
            n_acc.cl_quality     = i_data.quality_in;
            n_acc.cl_first_index = w_first_index;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap_limit     <= GAP_LIMIT_RESET;
            r_snr_threshold <= SNR_THRESHOLD_RESET;
            r_open          <= 1'b0;
            r_item_counter  <= '0;
            r_out_valid     <= 1'b0;
            r_skid_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_GAP_LIMIT:     r_gap_limit     <= i_cfg_data[GAP_W-1:0];
                    REG_SNR_THRESHOLD: r_snr_threshold <= i_cfg_data[SNR_W-1:0];
                    default:           ;
                endcase
            end
            if (w_accept) begin
                if (w_flush) begin
                    r_open         <= 1'b0;
                    r_item_counter <= '0;
                end else begin
                    r_open <= 1'b1;
                    if (r_item_counter != INDEX_MAX) begin
                        r_item_counter <= r_item_counter + INDEX_WIDTH'(1);
                    end
                end
            end
            if (w_out_free) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= w_emit;
                end
            end else if (w_emit) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    // Cluster and result payload.
    always_ff @(posedge i_clk) begin
        if (w_accept && !w_flush) begin
            r_acc <= n_acc;
        end
        if (w_out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (w_emit) begin
                r_out <= r_acc;
            end
        end else if (w_emit) begin
            r_skid <= r_acc;
        end
    end

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry occupied while output register is empty");

    a_no_emit_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> !w_emit)
        else $error("result produced while skid entry is occupied");

    a_flush_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_flush) |=> (!r_open && r_item_counter == '0))
        else $error("flush did not empty the block");

    a_trigger_opens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !w_flush) |=> r_open)
        else $error("trigger left no open cluster");

endmodule

/* tb/tb_time_gap_trigger_clusterer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_time_gap_trigger_clusterer
// Self-checking bench for the gap-based trigger clusterer. Feeds mostly
// time-ordered triggers around the join gap and the SNR threshold, plus raw
// noise and flushes. It tracks the open cluster alongside the block and
// checks every emitted cluster field by field, while both channels idle at
// random outside one steady phase.
// ----------------------------------------------------------------------------
module tb_time_gap_trigger_clusterer;
    import tgtc_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int SETTLE      = 8;

    // Tracks the open cluster and holds the clusters that are still owed.
    class cluster_tracker;
        logic [GAP_W-1:0]       gap_limit;
        logic [SNR_W-1:0]       snr_threshold;
        bit                     is_open;
        t_cluster               acc;
        logic [INDEX_WIDTH-1:0] trig_count;
        t_cluster               pending_clusters[$];
        int                     errors;

        function new();
            gap_limit     = GAP_LIMIT_RESET;
            snr_threshold = SNR_THRESHOLD_RESET;
            errors        = 0;
            clear();
        endfunction

        function void clear();
            is_open    = 1'b0;
            acc        = '0;
            trig_count = '0;
        endfunction

        function void load_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
            if (idx == REG_GAP_LIMIT) begin
                gap_limit = GAP_W'(value);
            end else if (idx == REG_SNR_THRESHOLD) begin
                snr_threshold = SNR_W'(value);
            end
        endfunction

        function void close_cluster();
            if (is_open && acc.cl_snr >= snr_threshold) begin
                pending_clusters.push_back(acc);
            end
        endfunction

        function void take_peak(t_trig t);
            acc.cl_snr     = t.snr_in;
            acc.cl_amp     = t.amp_in;
            acc.cl_time    = t.peak_time;
            acc.cl_freq    = t.peak_freq;
            acc.cl_quality = t.quality_in;
        endfunction

        function void absorb_item(t_trig t);
            bit joins;
            if (t.cmd == CMD_FLUSH) begin
                close_cluster();
                clear();
                return;
            end
            // A start before the cluster end is a negative gap and always joins.
            joins = is_open && (t.start_time < acc.cl_end ||
                    64'(t.start_time) - 64'(acc.cl_end) < 64'(gap_limit));
            if (joins) begin
                if (acc.cl_size != '1) begin
                    acc.cl_size = acc.cl_size + CNT_W'(1);
                end
                if (t.end_time > acc.cl_end) acc.cl_end = t.end_time;
                if (t.start_time < acc.cl_start) acc.cl_start = t.start_time;
                if (t.high_freq > acc.cl_high_freq) acc.cl_high_freq = t.high_freq;
                if (t.low_freq < acc.cl_low_freq) acc.cl_low_freq = t.low_freq;
                if (t.snr_in > acc.cl_snr) take_peak(t);
            end else begin
                close_cluster();
                is_open          = 1'b1;
                acc.cl_start     = t.start_time;
                acc.cl_end       = t.end_time;
                acc.cl_low_freq  = t.low_freq;
                acc.cl_high_freq = t.high_freq;
                acc.cl_size      = CNT_W'(1);
                take_peak(t);
                acc.cl_first_index = (trig_count > {CNT_W{1'b1}}) ?
                                     {CNT_W{1'b1}} : CNT_W'(trig_count);
            end
            if (trig_count != '1) begin
                trig_count = trig_count + INDEX_WIDTH'(1);
            end
        endfunction

        function void check_field(string label, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t ns: %s mismatch, expected %h, actual %h",
                         $time, label, want, got);
            end
        endfunction

        function void check_cluster(t_cluster got);
            t_cluster want;
            if (pending_clusters.size() == 0) begin
                errors++;
                $display("%0t ns: cluster not expected, expected none, actual %h",
                         $time, got);
                return;
            end
            want = pending_clusters.pop_front();
            check_field("cl_time", want.cl_time, got.cl_time);
            check_field("cl_start", want.cl_start, got.cl_start);
            check_field("cl_end", want.cl_end, got.cl_end);
            check_field("cl_freq", want.cl_freq, got.cl_freq);
            check_field("cl_low_freq", want.cl_low_freq, got.cl_low_freq);
            check_field("cl_high_freq", want.cl_high_freq, got.cl_high_freq);
            check_field("cl_snr", want.cl_snr, got.cl_snr);
            check_field("cl_amp", want.cl_amp, got.cl_amp);
            check_field("cl_quality", want.cl_quality, got.cl_quality);
            check_field("cl_first_index", want.cl_first_index, got.cl_first_index);
            check_field("cl_size", want.cl_size, got.cl_size);
        endfunction
    endclass

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_valid     = 1'b0;
    logic                 o_stall;
    t_trig                i_data      = '0;
    logic                 o_valid;
    logic                 i_stall     = 1'b0;
    t_cluster             o_data;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data  = '0;

    bit             steady  = 1'b0;
    cluster_tracker tracker = new();

    time_gap_trigger_clusterer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Cluster side: check what is taken, then choose the next stall.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && !i_stall) begin
            tracker.check_cluster(o_data);
        end
        i_stall <= !steady && ($urandom_range(99) < 26);
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic t_trig noise_item();
        t_trig t;
        t.cmd        = 1'($urandom_range(1));
        t.peak_time  = TIME_W'(rand64());
        t.start_time = TIME_W'(rand64());
        t.end_time   = TIME_W'(rand64());
        t.peak_freq  = FREQ_W'(rand64());
        t.low_freq   = FREQ_W'(rand64());
        t.high_freq  = FREQ_W'(rand64());
        t.snr_in     = $urandom();
        t.amp_in     = rand64();
        t.quality_in = rand64();
        return t;
    endfunction

    function automatic t_trig flush_item();
        t_trig t;
        t = noise_item();
        t.cmd = CMD_FLUSH;
        return t;
    endfunction

    function automatic t_trig tile(input logic [63:0] start, input logic [63:0] span,
                                   input logic [SNR_W-1:0] snr);
        t_trig t;
        t = noise_item();
        t.cmd        = CMD_TRIGGER;
        t.start_time = TIME_W'(start);
        t.end_time   = TIME_W'(start + span);
        t.peak_time  = TIME_W'(start + rand64() % (span + 1));
        t.snr_in     = snr;
        return t;
    endfunction

    // SNR values cluster around the threshold and the current peak so that
    // ties and near misses come up often.
    function automatic logic [SNR_W-1:0] pick_snr();
        case ($urandom_range(5))
            0: return $urandom();
            1: return tracker.snr_threshold;
            2: return tracker.snr_threshold - SNR_W'(1);
            3: return tracker.acc.cl_snr;
            4: return SNR_W'($urandom_range(0, 20)) << 16;
            default: return tracker.snr_threshold + SNR_W'($urandom_range(1, 65536));
        endcase
    endfunction

    // A trigger placed against the open cluster's end: overlapping, inside
    // the gap, just short of it, exactly on it, or well beyond it.
    function automatic t_trig next_tile();
        logic [63:0] anchor, gap, start, span;
        anchor = 64'(tracker.acc.cl_end);
        gap    = 64'(tracker.gap_limit);
        case ($urandom_range(9))
            0, 1:    start = anchor - 64'($urandom_range(0, 5000));
            2, 3, 4: start = anchor + ((gap == 0) ? 64'd0 : rand64() % gap);
            5:       start = anchor + gap - 1;
            6:       start = anchor + gap;
            default: start = anchor + gap + rand64() % (64'd1 << 36);
        endcase
        span = ($urandom_range(3) == 0) ? rand64() % (64'd1 << 34) :
                                          64'($urandom_range(0, 4096));
        return tile(start, span, pick_snr());
    endfunction

    function automatic t_trig pick_item();
        int roll;
        t_trig t;
        roll = $urandom_range(99);
        if (roll < 6) return flush_item();
        if (roll < 16) begin
            t = noise_item();
            t.cmd = CMD_TRIGGER;
            return t;
        end
        return next_tile();
    endfunction

    task automatic send_item(input t_trig t);
        while (!steady && $urandom_range(99) < 26) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= t;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        tracker.absorb_item(t);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (tracker.pending_clusters.size() != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic load_settings(input logic [CFG_W-1:0] gap, input logic [CFG_W-1:0] thr);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_GAP_LIMIT;
        i_cfg_data  <= gap;
        @(posedge i_clk);
        i_cfg_index <= REG_SNR_THRESHOLD;
        i_cfg_data  <= thr;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        tracker.load_register(REG_GAP_LIMIT, gap);
        tracker.load_register(REG_SNR_THRESHOLD, thr);
    endtask

    task automatic run_directed();
        logic [63:0] gap, mark;
        t_trig t;
        gap  = 64'(tracker.gap_limit);
        mark = 64'd100 << 32;
        send_item(flush_item());
        send_item(t_trig'('0));
        send_item(flush_item());
        t = '1;
        t.cmd = CMD_TRIGGER;
        send_item(t);
        send_item(flush_item());
        // Join just inside the gap with a tied SNR, then an overlapping
        // louder tile, then a trigger exactly on the gap that closes it.
        send_item(tile(mark, 1000, 32'd20 << 16));
        send_item(tile(64'(tracker.acc.cl_end) + gap - 1, 500, 32'd20 << 16));
        send_item(tile(64'(tracker.acc.cl_end) - 10, 200, 32'd30 << 16));
        send_item(tile(64'(tracker.acc.cl_end) + gap, 100, 32'd5 << 16));
        send_item(tile(64'(tracker.acc.cl_end) + 3 * gap, 100, tracker.snr_threshold));
        send_item(tile(64'(tracker.acc.cl_end) + gap / 2, 100,
                       tracker.snr_threshold - SNR_W'(1)));
        send_item(flush_item());
        // The stream index starts again from zero after a flush.
        send_item(tile(mark, 50, 32'd40 << 16));
        send_item(tile(mark + 4 * gap, 50, 32'd15 << 16));
        send_item(flush_item());
    endtask

    task automatic run_phase(input int count, input logic [CFG_W-1:0] gap,
                             input logic [CFG_W-1:0] thr);
        int pause_at;
        wait_drained();
        load_settings(gap, thr);
        pause_at = $urandom_range(count - 1);
        for (int k = 0; k < count; k++) begin
            if (k == pause_at) wait_drained();
            send_item(pick_item());
        end
    endtask

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_stall === 1'b0) || (o_valid === 1'b1 && !i_stall)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("** time_gap_trigger_clusterer: FAILED **");
        $finish;
    end

    initial begin : stimulus
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        run_phase(250, 40'd1 << 32, 40'd655360);
        steady <= 1'b1;
        run_phase(200, '0, '0);
        steady <= 1'b0;
        run_phase(150, 40'hFF_FFFF_FFFF, 40'hFF_FFFF_FFFF);
        run_phase(250, 40'd1000, 40'd655360);
        run_phase(200, CFG_W'(rand64() % (64'd1 << 36)),
                  CFG_W'($urandom_range(0, 40)) << 16);
        run_phase(200, CFG_W'(GAP_LIMIT_RESET), CFG_W'(SNR_THRESHOLD_RESET));
        wait_drained();
        if (tracker.errors == 0) begin
            $display("** time_gap_trigger_clusterer: PASSED **");
        end else begin
            $display("** time_gap_trigger_clusterer: FAILED **");
        end
        $finish;
    end

endmodule
